>>> rtl/hrc_pkg.sv
// Shared types, constants and segment decode for the button auto-repeat counter.
`timescale 1ns / 1ps
package hrc_pkg;

	localparam int unsigned HRC_QUEUE_DEPTH = 2;
	localparam int unsigned HRC_ADDR_W = 3;
	localparam int unsigned HRC_DATA_W = 32;
	localparam int unsigned HRC_CNT_W = 16;

	localparam logic [HRC_ADDR_W-1:0] HRC_ADDR_HOLD_THRESHOLD = 3'd0;
	localparam logic [HRC_CNT_W-1:0] HRC_THRESHOLD_RESET = 16'd150;
	localparam logic [HRC_CNT_W-1:0] HRC_CNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_KEEP = 2'd0,
		OP_INC  = 2'd1,
		OP_DEC  = 2'd2
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef logic [3:0] bcd_t;

	function automatic logic [6:0] seg_decode(input bcd_t d);
		logic [6:0] s;
		unique case (d)
			4'd0: s = 7'h3f;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5b;
			4'd3: s = 7'h4f;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6d;
			4'd6: s = 7'h7d;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7f;
			4'd9: s = 7'h6f;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/hrc_front.sv
// Front end: takes button samples, tracks press/hold state and classifies each tick.
`timescale 1ns / 1ps
module hrc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         up_level,
	input  logic                         down_level,
	input  logic [hrc_pkg::HRC_CNT_W-1:0] hold_threshold,
	input  hrc_pkg::q_status_t           q_status,
	output logic                         push,
	output hrc_pkg::op_t                 push_op
);
	import hrc_pkg::*;

	logic [1:0]           level;
	logic [1:0]           released_q;
	logic [1:0]           released_nx;
	logic [HRC_CNT_W-1:0] hold_q  [2];
	logic [HRC_CNT_W-1:0] hold_nx [2];
	logic [1:0]           step;

	assign level = {down_level, up_level};
	assign in_stall = q_status.full;
	assign push = in_valid && !q_status.full;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			released_nx[i] = released_q[i];
			hold_nx[i] = hold_q[i];
			step[i] = 1'b0;
			if (!level[i]) begin
				if (released_q[i]) begin
					released_nx[i] = 1'b0;
					hold_nx[i] = '0;
					step[i] = 1'b1;
				end else begin
					if (hold_q[i] != HRC_CNT_MAX) begin
						hold_nx[i] = hold_q[i] + 1'b1;
					end
					step[i] = hold_nx[i] > hold_threshold;
				end
			end else begin
				released_nx[i] = 1'b1;
				hold_nx[i] = '0;
			end
		end
	end

	always_comb begin
		case (step)
			2'b01:   push_op = OP_INC;
			2'b10:   push_op = OP_DEC;
			default: push_op = OP_KEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= 2'b11;
			hold_q[0] <= '0;
			hold_q[1] <= '0;
		end else if (push) begin
			released_q <= released_nx;
			hold_q[0] <= hold_nx[0];
			hold_q[1] <= hold_nx[1];
		end
	end

endmodule

>>> rtl/hrc_queue.sv
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps
module hrc_queue #(
	parameter int unsigned DEPTH = hrc_pkg::HRC_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hrc_pkg::op_t       wdata,
	input  logic               pop,
	output hrc_pkg::op_t       rdata,
	output hrc_pkg::q_status_t status
);
	import hrc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] level_q;

	assign status.full = (level_q == CW'(DEPTH));
	assign status.empty = (level_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/hrc_back.sv
// Back end: applies queued steps to the count, keeps decimal digits, registers results.
`timescale 1ns / 1ps
module hrc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hrc_pkg::q_status_t            q_status,
	input  hrc_pkg::op_t                  op,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hrc_pkg::HRC_CNT_W-1:0] count_value,
	output logic [6:0]                    seg_units,
	output logic [6:0]                    seg_tens,
	output logic [6:0]                    seg_hundreds
);
	import hrc_pkg::*;

	logic [HRC_CNT_W-1:0] count_q;
	logic [HRC_CNT_W-1:0] count_nx;
	bcd_t                 dig_q  [3];
	bcd_t                 dig_nx [3];
	logic                 out_valid_q;
	logic [6:0]           seg_u_q;
	logic [6:0]           seg_t_q;
	logic [6:0]           seg_h_q;
	logic                 carry;

	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// low three decimal digits follow the count; wrap points jump to 000 / 535
	always_comb begin
		count_nx = count_q;
		dig_nx[0] = dig_q[0];
		dig_nx[1] = dig_q[1];
		dig_nx[2] = dig_q[2];
		carry = 1'b1;
		unique case (op)
			OP_INC: begin
				count_nx = count_q + 1'b1;
				if (count_q == HRC_CNT_MAX) begin
					dig_nx[0] = 4'd0;
					dig_nx[1] = 4'd0;
					dig_nx[2] = 4'd0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (carry) begin
							if (dig_q[i] == 4'd9) begin
								dig_nx[i] = 4'd0;
							end else begin
								dig_nx[i] = dig_q[i] + 1'b1;
								carry = 1'b0;
							end
						end
					end
				end
			end
			OP_DEC: begin
				count_nx = count_q - 1'b1;
				if (count_q == '0) begin
					dig_nx[0] = 4'd5;
					dig_nx[1] = 4'd3;
					dig_nx[2] = 4'd5;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (carry) begin
							if (dig_q[i] == 4'd0) begin
								dig_nx[i] = 4'd9;
							end else begin
								dig_nx[i] = dig_q[i] - 1'b1;
								carry = 1'b0;
							end
						end
					end
				end
			end
			OP_KEEP: begin
				count_nx = count_q;
			end
			default: begin
				count_nx = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dig_q[0] <= 4'd0;
			dig_q[1] <= 4'd0;
			dig_q[2] <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q <= count_nx;
				dig_q[0] <= dig_nx[0];
				dig_q[1] <= dig_nx[1];
				dig_q[2] <= dig_nx[2];
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_u_q <= seg_decode(dig_nx[0]);
			seg_t_q <= (count_nx < 16'd10) ? 7'h00 : seg_decode(dig_nx[1]);
			seg_h_q <= (count_nx < 16'd100) ? 7'h00 : seg_decode(dig_nx[2]);
		end
	end

	assign out_valid = out_valid_q;
	assign count_value = count_q;
	assign seg_units = seg_u_q;
	assign seg_tens = seg_t_q;
	assign seg_hundreds = seg_h_q;

endmodule

>>> rtl/hold_repeat_updown_counter_7seg_unit.sv
// Top level of the button auto-repeat up/down counter with seven-segment decode.
// Usage:
//   Input channel (in_valid/in_stall, up_level, down_level): one transaction per
//   poll tick carrying the active-low button levels.
//   Output channel (out_valid/out_stall): one transaction per input tick with the
//   count and three segment codes (gfedcba, leading zeros blanked).
//   APB port: register 0 at address 0 is hold_threshold (16 bits, reset 150).
// An accepted tick is stored in the queue, then applied and registered in the back end.
// Throughput: one tick per cycle while the output is not stalled; the back end
//   registers its combinational count/digit update, as the front end does its state.
// A two-entry queue sits between front and back; when the receiver stalls the
//   output register holds, the queue fills and in_stall rises once it is full.
// Reset clears the count, hold counts and queue, sets both buttons released
//   and loads the threshold with 150. Output is invalid after reset.
`timescale 1ns / 1ps
module hold_repeat_updown_counter_7seg_unit #(
	parameter int unsigned QUEUE_DEPTH = hrc_pkg::HRC_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hrc_pkg::HRC_ADDR_W-1:0] paddr,
	input  logic [hrc_pkg::HRC_DATA_W-1:0] pwdata,
	output logic [hrc_pkg::HRC_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           up_level,
	input  logic                           down_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hrc_pkg::HRC_CNT_W-1:0]  count_value,
	output logic [6:0]                     seg_units,
	output logic [6:0]                     seg_tens,
	output logic [6:0]                     seg_hundreds
);
	import hrc_pkg::*;

	logic [HRC_CNT_W-1:0] threshold_q;
	q_status_t            q_status;
	logic                 push;
	logic                 pop;
	op_t                  push_op;
	op_t                  pop_op;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= HRC_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == HRC_ADDR_HOLD_THRESHOLD)) begin
			threshold_q <= pwdata[HRC_CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == HRC_ADDR_HOLD_THRESHOLD) begin
			prdata = {{(HRC_DATA_W-HRC_CNT_W){1'b0}}, threshold_q};
		end
	end

	hrc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.up_level       (up_level),
		.down_level     (down_level),
		.hold_threshold (threshold_q),
		.q_status       (q_status),
		.push           (push),
		.push_op        (push_op)
	);

	hrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_op),
		.pop    (pop),
		.rdata  (pop_op),
		.status (q_status)
	);

	hrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.op           (pop_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.count_value  (count_value),
		.seg_units    (seg_units),
		.seg_tens     (seg_tens),
		.seg_hundreds (seg_hundreds)
	);

`ifndef SYNTHESIS
	a_blank_small: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (count_value < 16'd10) |-> (seg_tens == 7'h00) && (seg_hundreds == 7'h00))
		else $error("leading digits not blanked");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !q_status.empty || out_valid)
		else $error("accepted transaction vanished");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && !(pop && q_status.empty))
		else $error("queue status inconsistent");
`endif

endmodule
